// ===== hdl/escaped_byte_page_programmer_assert.svh =====
// ----------------------------------------------------------------------------
// Escaped byte page programmer assertion macros
// Concurrent assertion shorthands clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ESCAPED_BYTE_PAGE_PROGRAMMER_ASSERT_SVH
`define ESCAPED_BYTE_PAGE_PROGRAMMER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EBPP_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EBPP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/ebpp_pkg.sv =====
// ----------------------------------------------------------------------------
// Escaped byte page programmer package
// Shared constants, result codes, controller states and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package ebpp_pkg;

   localparam int PAGE_BYTES_DEFAULT = 64;

   localparam logic [7:0] ESC_BYTE = 8'hAA;
   localparam logic [7:0] END_BYTE = 8'hB0;

   localparam logic [8:0] PAGE_LIMIT_RESET = 9'd128;

   localparam int CSR_ADDR_W = 3;
   localparam logic [0:0] REG_PAGE_LIMIT = 1'b0;

   typedef enum logic [2:0] {
      OP_ERASE = 3'd0,
      OP_FILL  = 3'd1,
      OP_WRITE = 3'd2,
      OP_ERROR = 3'd3,
      OP_DONE  = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ERASE,
      ST_FILL,
      ST_WRITE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic   store;
      logic   set_escape;
      logic   clear_escape;
      logic   set_finished;
      logic   page_inc;
      logic   fill_clear;
      logic   word_clear;
      logic   word_inc;
      logic   emit;
      op_type op;
      logic   last;
   } cmd_type;

   typedef struct packed {
      logic escape_armed;
      logic finished;
      logic esc_byte;
      logic end_byte;
      logic at_limit;
      logic fill_nonzero;
      logic fill_near_full;
      logic last_word;
      logic out_free;
   } status_type;

endpackage

// ===== hdl/ebpp_ctrl.sv =====
// ----------------------------------------------------------------------------
// Escaped byte page programmer controller
// Decodes each accepted byte and sequences the erase, fill, write and done
// results of a page flush.
// ----------------------------------------------------------------------------
module ebpp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ebpp_pkg::status_type  status,
   output ebpp_pkg::cmd_type     cmd,
   output ebpp_pkg::state_type   state
);

   ebpp_pkg::state_type state_ff;
   ebpp_pkg::state_type state_in;
   logic                end_flush_ff;
   logic                end_flush_in;
   logic                accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ebpp_pkg::ST_IDLE;
         end_flush_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         end_flush_ff <= end_flush_in;
      end
   end

   assign state     = state_ff;
   assign req_stall = !((state_ff == ebpp_pkg::ST_IDLE) && status.out_free);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in     = state_ff;
      end_flush_in = end_flush_ff;
      cmd          = '0;
      cmd.op       = ebpp_pkg::OP_ERASE;
      unique case (state_ff)
         ebpp_pkg::ST_IDLE: begin
            if (accept && !status.finished) begin
               if (!status.escape_armed && status.esc_byte) begin
                  cmd.set_escape = 1'b1;
               end else if (status.escape_armed && status.end_byte) begin
                  cmd.clear_escape = 1'b1;
                  cmd.set_finished = 1'b1;
                  if (status.fill_nonzero && !status.at_limit) begin
                     state_in     = ebpp_pkg::ST_ERASE;
                     end_flush_in = 1'b1;
                  end else begin
                     cmd.emit       = 1'b1;
                     cmd.op         = ebpp_pkg::OP_DONE;
                     cmd.last       = 1'b1;
                     cmd.fill_clear = 1'b1;
                  end
               end else begin
                  cmd.clear_escape = 1'b1;
                  if (status.at_limit) begin
                     cmd.emit = 1'b1;
                     cmd.op   = ebpp_pkg::OP_ERROR;
                     cmd.last = 1'b1;
                  end else begin
                     cmd.store = 1'b1;
                     if (status.fill_near_full) begin
                        state_in     = ebpp_pkg::ST_ERASE;
                        end_flush_in = 1'b0;
                     end
                  end
               end
            end
         end
         ebpp_pkg::ST_ERASE: begin
            if (status.out_free) begin
               cmd.emit       = 1'b1;
               cmd.op         = ebpp_pkg::OP_ERASE;
               cmd.word_clear = 1'b1;
               state_in       = ebpp_pkg::ST_FILL;
            end
         end
         ebpp_pkg::ST_FILL: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.op   = ebpp_pkg::OP_FILL;
               if (status.last_word) begin
                  state_in = ebpp_pkg::ST_WRITE;
               end else begin
                  cmd.word_inc = 1'b1;
               end
            end
         end
         ebpp_pkg::ST_WRITE: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.op   = ebpp_pkg::OP_WRITE;
               cmd.last = !end_flush_ff;
               if (end_flush_ff) begin
                  state_in = ebpp_pkg::ST_DONE;
               end else begin
                  cmd.page_inc   = 1'b1;
                  cmd.fill_clear = 1'b1;
                  state_in       = ebpp_pkg::ST_IDLE;
               end
            end
         end
         ebpp_pkg::ST_DONE: begin
            if (status.out_free) begin
               cmd.emit       = 1'b1;
               cmd.op         = ebpp_pkg::OP_DONE;
               cmd.last       = 1'b1;
               cmd.fill_clear = 1'b1;
               state_in       = ebpp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ebpp_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hdl/ebpp_datapath.sv =====
// ----------------------------------------------------------------------------
// Escaped byte page programmer datapath
// Holds the stream state, the page buffer and the result output register,
// and carries out the controller's commands.
// ----------------------------------------------------------------------------
module ebpp_datapath #(
   parameter int PAGE_BYTES = ebpp_pkg::PAGE_BYTES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [7:0]           req_data_byte,
   input  logic                 limit_wr,
   input  logic [8:0]           limit_data,
   output logic [8:0]           page_limit,
   input  ebpp_pkg::cmd_type    cmd,
   output ebpp_pkg::status_type status,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [2:0]           rsp_op,
   output logic [7:0]           rsp_page_index,
   output logic [4:0]           rsp_word_offset,
   output logic [15:0]          rsp_fill_word,
   output logic                 rsp_last
);

   localparam int FW     = $clog2(PAGE_BYTES + 1);
   localparam int NWORDS = (PAGE_BYTES + 1) / 2;
   localparam int WA     = (NWORDS > 1) ? $clog2(NWORDS) : 1;

   logic          escape_armed_ff, escape_armed_in;
   logic          finished_ff, finished_in;
   logic [8:0]    page_count_ff, page_count_in;
   logic [8:0]    page_limit_ff, page_limit_in;
   logic [FW-1:0] fill_count_ff, fill_count_in;
   logic [WA-1:0] word_cnt_ff, word_cnt_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    rsp_op_ff, rsp_op_in;
   logic [7:0]    rsp_page_ff, rsp_page_in;
   logic [4:0]    rsp_offset_ff, rsp_offset_in;
   logic [15:0]   rsp_word_ff, rsp_word_in;
   logic          rsp_last_ff, rsp_last_in;

   // The buffer keeps even bytes and odd bytes in two lanes of one word row.
   logic [7:0]    lo_mem [NWORDS];
   logic [7:0]    hi_mem [NWORDS];
   logic [7:0]    lo_rd_ff;
   logic [7:0]    hi_rd_ff;

   logic [FW-1:0] fill_half;
   logic [WA-1:0] wr_addr;
   logic [FW:0]   lo_idx;
   logic [FW:0]   hi_idx;
   logic [FW:0]   fill_ext;
   logic [15:0]   masked_word;
   logic          out_free;
   logic          page_op;

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_armed_ff <= 1'b0;
         finished_ff     <= 1'b0;
         page_count_ff   <= '0;
         page_limit_ff   <= ebpp_pkg::PAGE_LIMIT_RESET;
         fill_count_ff   <= '0;
         word_cnt_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         escape_armed_ff <= escape_armed_in;
         finished_ff     <= finished_in;
         page_count_ff   <= page_count_in;
         page_limit_ff   <= page_limit_in;
         fill_count_ff   <= fill_count_in;
         word_cnt_ff     <= word_cnt_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_op_ff     <= rsp_op_in;
      rsp_page_ff   <= rsp_page_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_word_ff   <= rsp_word_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign fill_half = fill_count_ff >> 1;
   assign wr_addr   = fill_half[WA-1:0];

   // The read address follows the next word count so that the registered
   // read data always belongs to the current word count.
   always_ff @(posedge clock) begin
      if (cmd.store && !fill_count_ff[0]) begin
         lo_mem[wr_addr] <= req_data_byte;
      end
      if (cmd.store && fill_count_ff[0]) begin
         hi_mem[wr_addr] <= req_data_byte;
      end
      lo_rd_ff <= lo_mem[word_cnt_in];
      hi_rd_ff <= hi_mem[word_cnt_in];
   end

   always_comb begin
      escape_armed_in = escape_armed_ff;
      if (cmd.set_escape) begin
         escape_armed_in = 1'b1;
      end else if (cmd.clear_escape) begin
         escape_armed_in = 1'b0;
      end
      finished_in   = finished_ff || cmd.set_finished;
      page_count_in = cmd.page_inc ? page_count_ff + 9'd1 : page_count_ff;
      page_limit_in = limit_wr ? limit_data : page_limit_ff;
      fill_count_in = fill_count_ff;
      if (cmd.fill_clear) begin
         fill_count_in = '0;
      end else if (cmd.store) begin
         fill_count_in = fill_count_ff + FW'(1);
      end
      word_cnt_in = word_cnt_ff;
      if (cmd.word_clear) begin
         word_cnt_in = '0;
      end else if (cmd.word_inc) begin
         word_cnt_in = word_cnt_ff + WA'(1);
      end
   end

   // Bytes at or past the fill count are the zero padding of a short page.
   assign lo_idx      = (FW + 1)'({word_cnt_ff, 1'b0});
   assign hi_idx      = (FW + 1)'({word_cnt_ff, 1'b1});
   assign fill_ext    = {1'b0, fill_count_ff};
   assign masked_word = {(hi_idx < fill_ext) ? hi_rd_ff : 8'h00,
                         (lo_idx < fill_ext) ? lo_rd_ff : 8'h00};

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign page_op  = (cmd.op == ebpp_pkg::OP_ERASE) || (cmd.op == ebpp_pkg::OP_FILL)
                  || (cmd.op == ebpp_pkg::OP_WRITE);

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_op_in     = rsp_op_ff;
      rsp_page_in   = rsp_page_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_last_in   = rsp_last_ff;
      if (cmd.emit) begin
         rsp_valid_in  = 1'b1;
         rsp_op_in     = cmd.op;
         rsp_page_in   = page_op ? page_count_ff[7:0] : 8'h00;
         rsp_offset_in = (cmd.op == ebpp_pkg::OP_FILL) ? 5'(word_cnt_ff) : 5'd0;
         rsp_word_in   = (cmd.op == ebpp_pkg::OP_FILL) ? masked_word : 16'h0000;
         rsp_last_in   = cmd.last;
      end
   end

   always_comb begin
      status                = '0;
      status.escape_armed   = escape_armed_ff;
      status.finished       = finished_ff;
      status.esc_byte       = (req_data_byte == ebpp_pkg::ESC_BYTE);
      status.end_byte       = (req_data_byte == ebpp_pkg::END_BYTE);
      status.at_limit       = (page_count_ff >= page_limit_ff);
      status.fill_nonzero   = (fill_count_ff != '0);
      status.fill_near_full = (fill_count_ff == FW'(PAGE_BYTES - 1));
      status.last_word      = (word_cnt_ff == WA'(NWORDS - 1));
      status.out_free       = out_free;
   end

   assign page_limit      = page_limit_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_op          = rsp_op_ff;
   assign rsp_page_index  = rsp_page_ff;
   assign rsp_word_offset = rsp_offset_ff;
   assign rsp_fill_word   = rsp_word_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// ===== hdl/escaped_byte_page_programmer.sv =====
// ----------------------------------------------------------------------------
// Escaped byte page programmer
// Loads an escaped byte stream into flash pages and issues page commands.
// ----------------------------------------------------------------------------
// An ordinary byte is taken whenever the controller is idle and the result
// register is free. The byte that completes a page holds the input for the
// page flush, which the controller sends one result per cycle while the output
// is not stalled: one erase, (PAGE_BYTES+1)/2 fill words read from the page
// buffer, and one write. The end marker after a partial page adds one more
// result for the done reply. The page buffer needs no clearing after reset;
// bytes beyond the fill level read as zero. The page limit register sits at
// byte address 0.
`include "escaped_byte_page_programmer_assert.svh"

module escaped_byte_page_programmer #(
   parameter int PAGE_BYTES = ebpp_pkg::PAGE_BYTES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_data_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [2:0]                      rsp_op,
   output logic [7:0]                      rsp_page_index,
   output logic [4:0]                      rsp_word_offset,
   output logic [15:0]                     rsp_fill_word,
   output logic                            rsp_last,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [ebpp_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);

   ebpp_pkg::cmd_type    cmd;
   ebpp_pkg::status_type status;
   ebpp_pkg::state_type  ctrl_state;
   logic                 limit_wr;
   logic [8:0]           page_limit;
   logic                 limit_sel;

   assign pready    = 1'b1;
   assign limit_sel = (paddr[2] == ebpp_pkg::REG_PAGE_LIMIT);
   assign limit_wr  = psel && penable && pwrite && limit_sel;
   assign prdata    = limit_sel ? {23'd0, page_limit} : 32'd0;

   ebpp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd),
      .state     (ctrl_state)
   );

   ebpp_datapath #(
      .PAGE_BYTES (PAGE_BYTES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_data_byte   (req_data_byte),
      .limit_wr        (limit_wr),
      .limit_data      (pwdata[8:0]),
      .page_limit      (page_limit),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_op          (rsp_op),
      .rsp_page_index  (rsp_page_index),
      .rsp_word_offset (rsp_word_offset),
      .rsp_fill_word   (rsp_fill_word),
      .rsp_last        (rsp_last)
   );

   // A byte is only taken while no flush is in progress.
   `EBPP_ASSERT_SAME(a_accept_in_idle, req_valid && !req_stall, ctrl_state == ebpp_pkg::ST_IDLE, "byte accepted during a flush")

   // Only the closing result of a byte carries last.
   `EBPP_ASSERT_SAME(a_last_op, rsp_valid && rsp_last, rsp_op == ebpp_pkg::OP_WRITE || rsp_op == ebpp_pkg::OP_ERROR || rsp_op == ebpp_pkg::OP_DONE, "last on a non-final result")

   // Word offset and fill data are zero outside fill results.
   `EBPP_ASSERT_SAME(a_fill_fields_zero, rsp_valid && rsp_op != ebpp_pkg::OP_FILL, rsp_word_offset == 5'd0 && rsp_fill_word == 16'h0000, "fill fields set outside a fill")

   // A write result always follows the last fill word of a page.
   `EBPP_ASSERT_NEXT(a_fill_to_write, ctrl_state == ebpp_pkg::ST_FILL && cmd.emit && status.last_word, ctrl_state == ebpp_pkg::ST_WRITE, "write did not follow the last fill word")

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escaped byte page programmer testbench
// Feeds an escaped firmware byte stream through the programmer, predicts
// every page command in a local model of the loader and checks each result
// word in order, across page limit settings and idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int PAGE_BYTES    = ebpp_pkg::PAGE_BYTES_DEFAULT;
   localparam int MAX_CMDS      = (PAGE_BYTES + 1) / 2 + 3;
   localparam int FLUSH_CYCLES  = (PAGE_BYTES + 1) / 2 + 8;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int PHASE_ITEMS   = 48;
   localparam int DIRECTED_ROWS = 20;
   localparam logic [ebpp_pkg::CSR_ADDR_W-1:0] LIMIT_ADDR = {ebpp_pkg::REG_PAGE_LIMIT, 2'b00};

   localparam int PHASE_SEND_IDLE [4]  = '{0, 62, 0, 11};
   localparam int PHASE_RECV_STALL [4] = '{0, 0, 62, 11};

   typedef struct packed {
      ebpp_pkg::op_type op;
      logic [7:0]       page;
      logic [4:0]       offset;
      logic [15:0]      word;
      logic             last;
   } page_cmd_type;

   typedef enum logic [1:0] {
      CHK_MODEL,
      CHK_SILENT,
      CHK_TYPED
   } row_check_type;

   typedef struct packed {
      logic          set_cfg;
      logic [8:0]    cfg_limit;
      logic [7:0]    data;
      row_check_type how;
      page_cmd_type  want;
   } stim_row_type;

   localparam page_cmd_type NO_CMD      = '{ebpp_pkg::OP_ERASE, 8'd0, 5'd0, 16'd0, 1'b0};
   localparam page_cmd_type ERROR_REPLY = '{ebpp_pkg::OP_ERROR, 8'd0, 5'd0, 16'd0, 1'b1};

   // Plain bytes, escaped bytes and an escaped escape under the reset limit,
   // then every stored byte refused at a zero limit, then the limit extremes.
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{1'b0, 9'd0,   8'h00, CHK_MODEL,  NO_CMD},
      '{1'b0, 9'd0,   8'hFF, CHK_MODEL,  NO_CMD},
      '{1'b0, 9'd0,   8'hAA, CHK_SILENT, NO_CMD},
      '{1'b0, 9'd0,   8'hAA, CHK_MODEL,  NO_CMD},
      '{1'b0, 9'd0,   8'h55, CHK_MODEL,  NO_CMD},
      '{1'b0, 9'd0,   8'hAA, CHK_SILENT, NO_CMD},
      '{1'b0, 9'd0,   8'h12, CHK_MODEL,  NO_CMD},
      '{1'b0, 9'd0,   8'h80, CHK_MODEL,  NO_CMD},
      '{1'b0, 9'd0,   8'h01, CHK_MODEL,  NO_CMD},
      '{1'b1, 9'd0,   8'h3C, CHK_TYPED,  ERROR_REPLY},
      '{1'b0, 9'd0,   8'hAA, CHK_SILENT, NO_CMD},
      '{1'b0, 9'd0,   8'hC3, CHK_TYPED,  ERROR_REPLY},
      '{1'b0, 9'd0,   8'hAA, CHK_SILENT, NO_CMD},
      '{1'b0, 9'd0,   8'hAA, CHK_TYPED,  ERROR_REPLY},
      '{1'b0, 9'd0,   8'hFF, CHK_TYPED,  ERROR_REPLY},
      '{1'b0, 9'd0,   8'h00, CHK_TYPED,  ERROR_REPLY},
      '{1'b1, 9'd256, 8'h7E, CHK_MODEL,  NO_CMD},
      '{1'b0, 9'd0,   8'h81, CHK_MODEL,  NO_CMD},
      '{1'b1, 9'd1,   8'h42, CHK_MODEL,  NO_CMD},
      '{1'b0, 9'd0,   8'h24, CHK_MODEL,  NO_CMD}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_op;
   logic [7:0]  rsp_page_index;
   logic [4:0]  rsp_word_offset;
   logic [15:0] rsp_fill_word;
   logic        rsp_last;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [ebpp_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   // Loader state as the predictor sees it.
   logic        esc_armed = 1'b0;
   logic        stream_ended = 1'b0;
   logic [8:0]  pages_done = 9'd0;
   int          fill_level = 0;
   logic [8:0]  limit_reg = ebpp_pkg::PAGE_LIMIT_RESET;
   logic [7:0]  page_data [PAGE_BYTES];

   page_cmd_type byte_cmds [MAX_CMDS];
   page_cmd_type pending_cmds [$];
   page_cmd_type seen;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int mismatches = 0;
   int cmds_checked = 0;
   int error_replies = 0;
   int bytes_sent = 0;
   int cycles = 0;
   logic ended_past_limit = 1'b0;

   escaped_byte_page_programmer #(
      .PAGE_BYTES(PAGE_BYTES)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_op         (rsp_op),
      .rsp_page_index (rsp_page_index),
      .rsp_word_offset(rsp_word_offset),
      .rsp_fill_word  (rsp_fill_word),
      .rsp_last       (rsp_last),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic add_cmd(inout int n, input ebpp_pkg::op_type op, input logic [7:0] page,
                          input logic [4:0] offset, input logic [15:0] word);
      byte_cmds[n] = '{op, page, offset, word, 1'b0};
      n++;
   endtask

   // Erase, one fill per little-endian word pair, then write.
   task automatic queue_page(inout int n);
      int i;
      logic [7:0] hi;
      add_cmd(n, ebpp_pkg::OP_ERASE, pages_done[7:0], 5'd0, 16'd0);
      for (i = 0; i < PAGE_BYTES; i += 2) begin
         hi = (i + 1 < PAGE_BYTES) ? page_data[i + 1] : 8'd0;
         add_cmd(n, ebpp_pkg::OP_FILL, pages_done[7:0], 5'(i >> 1), {hi, page_data[i]});
      end
      add_cmd(n, ebpp_pkg::OP_WRITE, pages_done[7:0], 5'd0, 16'd0);
   endtask

   // Works out the commands one received byte causes and advances the state.
   task automatic program_byte(input logic [7:0] b, output int n);
      int i;
      n = 0;
      if (stream_ended)
         return;
      if (!esc_armed && b == ebpp_pkg::ESC_BYTE) begin
         esc_armed = 1'b1;
         return;
      end
      if (esc_armed && b == ebpp_pkg::END_BYTE) begin
         esc_armed = 1'b0;
         stream_ended = 1'b1;
         if (fill_level > 0 && fill_level < PAGE_BYTES && pages_done < limit_reg) begin
            for (i = fill_level; i < PAGE_BYTES; i++)
               page_data[i] = 8'd0;
            queue_page(n);
         end
         fill_level = 0;
         add_cmd(n, ebpp_pkg::OP_DONE, 8'd0, 5'd0, 16'd0);
         byte_cmds[n - 1].last = 1'b1;
         return;
      end
      esc_armed = 1'b0;
      if (pages_done >= limit_reg) begin
         add_cmd(n, ebpp_pkg::OP_ERROR, 8'd0, 5'd0, 16'd0);
         byte_cmds[0].last = 1'b1;
         return;
      end
      if (fill_level >= PAGE_BYTES)
         fill_level = 0;
      page_data[fill_level] = b;
      fill_level++;
      if (fill_level == PAGE_BYTES) begin
         queue_page(n);
         byte_cmds[n - 1].last = 1'b1;
         pages_done = pages_done + 9'd1;
         fill_level = 0;
      end
   endtask

   task automatic put_byte(input logic [7:0] b, input row_check_type how,
                           input page_cmd_type want);
      int n;
      int i;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      do
         @(posedge clock);
      while (req_stall);
      program_byte(b, n);
      bytes_sent++;
      if (how == CHK_MODEL) begin
         for (i = 0; i < n; i++)
            pending_cmds.push_back(byte_cmds[i]);
      end else if (how == CHK_TYPED) begin
         pending_cmds.push_back(want);
      end
   endtask

   // Mostly plain bytes; now and then an escape with a random escaped byte.
   task automatic put_random();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < 8) begin
         put_byte(ebpp_pkg::ESC_BYTE, CHK_MODEL, NO_CMD);
         if ($urandom_range(0, 3) == 0)
            b = ebpp_pkg::ESC_BYTE;
      end
      if (esc_armed && b == ebpp_pkg::END_BYTE)
         b = b ^ 8'h01;
      put_byte(b, CHK_MODEL, NO_CMD);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_cmds.size() != 0)
         @(posedge clock);
      repeat (FLUSH_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic write, input logic [8:0] value,
                             output logic [31:0] rdata);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= write;
      paddr <= LIMIT_ADDR;
      pwdata <= {23'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      do
         @(posedge clock);
      while (!pready);
      rdata = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic check_limit();
      logic [31:0] rdata;
      csr_access(1'b0, 9'd0, rdata);
      if (rdata !== {23'd0, limit_reg}) begin
         mismatches++;
         $display("%0t: page limit read back: expected %0d, got %0d",
                  $time, limit_reg, rdata);
      end
   endtask

   task automatic set_limit(input logic [8:0] value);
      logic [31:0] rdata;
      csr_access(1'b1, value, rdata);
      limit_reg = value;
      check_limit();
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_cmds.size() == 0) begin
            mismatches++;
            $display("%0t: expected no word, got op %0d page %0d offset %0d word %h last %b",
                     $time, rsp_op, rsp_page_index, rsp_word_offset, rsp_fill_word,
                     rsp_last);
         end else begin
            seen = pending_cmds.pop_front();
            cmds_checked++;
            if (seen.op == ebpp_pkg::OP_ERROR)
               error_replies++;
            if (rsp_op !== seen.op || rsp_page_index !== seen.page
                || rsp_word_offset !== seen.offset || rsp_fill_word !== seen.word
                || rsp_last !== seen.last) begin
               mismatches++;
               $display("%0t: expected op %0d page %0d offset %0d word %h last %b,",
                        $time, seen.op, seen.page, seen.offset, seen.word, seen.last);
               $display("%0t:      got op %0d page %0d offset %0d word %h last %b",
                        $time, rsp_op, rsp_page_index, rsp_word_offset, rsp_fill_word,
                        rsp_last);
            end
         end
      end
      rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("%0t: run stopped after %0d cycles, %0d words still awaited",
                  $time, cycles, pending_cmds.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin : stimulus
      int row;
      int phase;
      int k;
      logic [7:0] b;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_limit();

      for (row = 0; row < DIRECTED_ROWS; row++) begin
         if (DIRECTED[row].set_cfg) begin
            drain();
            set_limit(DIRECTED[row].cfg_limit);
         end
         put_byte(DIRECTED[row].data, DIRECTED[row].how, DIRECTED[row].want);
      end

      // Every phase starts from an idle block, so the sender waits for the
      // last flush to come out before the limit changes.
      for (phase = 0; phase < 4; phase++) begin
         drain();
         send_idle_pct = PHASE_SEND_IDLE[phase];
         recv_stall_pct = PHASE_RECV_STALL[phase];
         case (phase)
            0: set_limit(9'd256);
            1: set_limit(pages_done + 9'd1);
            2: set_limit(ebpp_pkg::PAGE_LIMIT_RESET);
            default: set_limit(9'($urandom_range(int'(pages_done) + 1, 256)));
         endcase
         for (k = 0; k < PHASE_ITEMS; k++)
            put_random();
      end

      // Leave a partial page, then end the stream either under the limit,
      // where the page is padded, or at it, where the page is dropped.
      drain();
      set_limit(9'd256);
      do begin
         b = 8'($urandom_range(0, 255));
         // An escape left armed by the random phase must not end the stream here.
         if (b == ebpp_pkg::ESC_BYTE || (esc_armed && b == ebpp_pkg::END_BYTE))
            b = 8'h5A;
         put_byte(b, CHK_MODEL, NO_CMD);
      end while (fill_level == 0);
      if ($urandom_range(0, 1) == 1) begin
         drain();
         set_limit(pages_done);
         ended_past_limit = 1'b1;
      end
      put_byte(ebpp_pkg::ESC_BYTE, CHK_MODEL, NO_CMD);
      put_byte(ebpp_pkg::END_BYTE, CHK_MODEL, NO_CMD);
      put_byte(ebpp_pkg::ESC_BYTE, CHK_MODEL, NO_CMD);
      put_byte(ebpp_pkg::END_BYTE, CHK_MODEL, NO_CMD);
      put_byte(8'h00, CHK_MODEL, NO_CMD);
      put_byte(8'hFF, CHK_MODEL, NO_CMD);
      drain();

      $display("sent %0d bytes, checked %0d command words over %0d pages, %0d error replies",
               bytes_sent, cmds_checked, pages_done, error_replies);
      $display("the last partial page was %s",
               ended_past_limit ? "dropped at the page limit" : "padded and flushed");
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
